@@ hw/rtl/rbg_pkg.sv @@
// Shared widths, defaults, divider select codes and controller/datapath interface types.
package rbg_pkg;

  localparam int PRICE_W = 32;
  localparam int BAR_VOL_W = 32;
  localparam int VOL_W = 48;
  localparam int TIME_W = 48;
  localparam int ITER_W = $clog2(VOL_W);

  localparam int MAX_BRICKS_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  localparam logic [PRICE_W-1:0] BRICK_SIZE_RESET = PRICE_W'(100);

  typedef enum logic [1:0] {
    DIV_LEVEL,
    DIV_COUNT,
    DIV_SHARE
  } div_sel_t;

  typedef struct packed {
    logic     take_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_level_div;
    logic     load_count;
    logic     load_share;
    logic     emit;
  } rbg_cmd_t;

  typedef struct packed {
    logic restart;
    logic bs_zero;
    logic move;
    logic div_done;
    logic out_free;
    logic last;
  } rbg_stat_t;

endpackage

@@ hw/rtl/renko_brick_generator_unit.sv @@
// Top level of the Renko brick generator: controller, datapath and port wiring.
//
// One bar is taken at a time; in_ready is high only while the unit waits for a
// bar. A bar that continues a series and moves no brick goes back to waiting
// after the move check; otherwise it runs a 32-step divide for the brick count,
// a 48-step divide for the volume share and then one brick per cycle into the
// output register while out_ready allows. A bar that starts a series adds a
// 32-step divide to snap the level onto the brick grid. All divides run one
// after another on one shared bit-serial divider. The last brick of a bar may
// still wait in the output register while the next bar is accepted. brick_size
// is held in a register written through the cfg channel, which is always ready;
// write it only while no bar is in flight. Bricks per bar saturate at
// MAX_BRICKS with capped set on every brick of that bar; prices are taken
// modulo 2^PRICE_BITS.
module renko_brick_generator_unit import rbg_pkg::*; #(
  parameter int MAX_BRICKS = MAX_BRICKS_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // bar input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PRICE_W-1:0]   close_price,
  input  logic [BAR_VOL_W-1:0] bar_volume,
  input  logic [TIME_W-1:0]    bar_time,
  input  logic                 series_start,
  // brick output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TIME_W-1:0]    brick_time,
  output logic [PRICE_W-1:0]   brick_open,
  output logic [PRICE_W-1:0]   brick_close,
  output logic [PRICE_W-1:0]   brick_high,
  output logic [PRICE_W-1:0]   brick_low,
  output logic [VOL_W-1:0]     brick_volume,
  output logic                 brick_up,
  output logic                 last_brick,
  output logic                 capped,
  // configuration channel: brick size in ticks
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [PRICE_W-1:0]   brick_size
);

  rbg_cmd_t  cmd;
  rbg_stat_t stat;

  // accept every configuration transaction at once
  assign cfg_ready = 1'b1;

  rbg_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbg_datapath #(
    .MAX_BRICKS (MAX_BRICKS),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid & cfg_ready),
    .cfg_data     (brick_size),
    .close_price  (close_price),
    .bar_volume   (bar_volume),
    .bar_time     (bar_time),
    .series_start (series_start),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .brick_time   (brick_time),
    .brick_open   (brick_open),
    .brick_close  (brick_close),
    .brick_high   (brick_high),
    .brick_low    (brick_low),
    .brick_volume (brick_volume),
    .brick_up     (brick_up),
    .last_brick   (last_brick),
    .capped       (capped)
  );

endmodule

@@ hw/rtl/rbg_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions of a bar.
module rbg_divider import rbg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VOL_W-1:0]   dividend,
  input  logic [PRICE_W-1:0] divisor,
  input  logic [ITER_W-1:0]  iters_m1,
  output logic               done,
  output logic [VOL_W-1:0]   quotient,
  output logic [PRICE_W-1:0] remainder
);

  logic                busy;
  logic [ITER_W-1:0]   cnt;
  logic [VOL_W-1:0]    dq;
  logic [PRICE_W-1:0]  rem;
  logic [PRICE_W-1:0]  dvs;
  logic [PRICE_W:0]    rem_sh;
  logic [PRICE_W:0]    diff;
  logic                ge;

  assign rem_sh = {rem, dq[VOL_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters_m1;
      end else if (busy) begin
        cnt <= cnt - ITER_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift partial remainder left, subtract divisor when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[VOL_W-2:0], ge};
      rem <= ge ? diff[PRICE_W-1:0] : rem_sh[PRICE_W-1:0];
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

@@ hw/rtl/rbg_datapath.sv @@
// Datapath: brick size, level and volume state, divider operands and the output register.
module rbg_datapath import rbg_pkg::*; #(
  parameter int MAX_BRICKS = MAX_BRICKS_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [PRICE_W-1:0]   cfg_data,
  input  logic [PRICE_W-1:0]   close_price,
  input  logic [BAR_VOL_W-1:0] bar_volume,
  input  logic [TIME_W-1:0]    bar_time,
  input  logic                 series_start,
  input  rbg_cmd_t             cmd,
  output rbg_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TIME_W-1:0]    brick_time,
  output logic [PRICE_W-1:0]   brick_open,
  output logic [PRICE_W-1:0]   brick_close,
  output logic [PRICE_W-1:0]   brick_high,
  output logic [PRICE_W-1:0]   brick_low,
  output logic [VOL_W-1:0]     brick_volume,
  output logic                 brick_up,
  output logic                 last_brick,
  output logic                 capped
);

  localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int NW = $clog2(MAX_BRICKS + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_BRICKS);
  localparam int PAD = VOL_W - PRICE_W;

  logic [PRICE_W-1:0] bs_reg;
  logic [PW-1:0]      bs;
  logic [PW-1:0]      close_in;
  logic [PW-1:0]      close_r;
  logic [PW-1:0]      level;
  logic               level_valid;
  logic [VOL_W-1:0]   volume_sum;
  logic [TIME_W-1:0]  time_r;
  logic               up_r;
  logic               cap_r;
  logic [NW-1:0]      n_r;
  logic [NW-1:0]      cnt;
  logic [VOL_W-1:0]   share;

  logic [VOL_W:0]     vol_add;
  logic [PW:0]        lvl_plus;
  logic               up_move;
  logic               dn_move;
  logic [PW-1:0]      span;
  logic [PW-1:0]      lvl_div;
  logic [PW-1:0]      lvl_step;
  logic               cap_now;
  logic [NW-1:0]      n_now;
  logic               is_last;

  logic [VOL_W-1:0]   div_dividend;
  logic [PRICE_W-1:0] div_divisor;
  logic [ITER_W-1:0]  div_iters;
  logic               div_done;
  logic [VOL_W-1:0]   div_q;
  logic [PRICE_W-1:0] div_r;

  assign bs       = bs_reg[PW-1:0];
  assign close_in = close_price[PW-1:0];

  assign vol_add  = {1'b0, volume_sum} + (VOL_W + 1)'(bar_volume);
  assign lvl_plus = {1'b0, level} + {1'b0, bs};
  assign up_move  = ({1'b0, close_r} >= lvl_plus);
  assign dn_move  = (level >= close_r) && ((level - close_r) >= bs);
  assign span     = up_move ? (close_r - level) : (level - close_r);
  assign lvl_div  = close_r - div_r[PW-1:0];
  assign lvl_step = up_r ? (level + bs) : (level - bs);
  assign cap_now  = (div_q[PRICE_W-1:0] > PRICE_W'(MAX_BRICKS));
  assign n_now    = cap_now ? NMAX : div_q[NW-1:0];
  assign is_last  = (cnt == n_r - NW'(1));

  // pick operands for the shared divider; price divides run 32 steps
  always_comb begin
    case (cmd.div_sel)
      DIV_LEVEL: begin
        div_dividend = {PRICE_W'(close_in), {PAD{1'b0}}};
        div_divisor  = PRICE_W'(bs);
        div_iters    = ITER_W'(PRICE_W - 1);
      end
      DIV_COUNT: begin
        div_dividend = {PRICE_W'(span), {PAD{1'b0}}};
        div_divisor  = PRICE_W'(bs);
        div_iters    = ITER_W'(PRICE_W - 1);
      end
      DIV_SHARE: begin
        div_dividend = volume_sum;
        div_divisor  = PRICE_W'(n_now);
        div_iters    = ITER_W'(VOL_W - 1);
      end
      default: begin
        div_dividend = volume_sum;
        div_divisor  = PRICE_W'(n_r);
        div_iters    = ITER_W'(VOL_W - 1);
      end
    endcase
  end

  rbg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .iters_m1  (div_iters),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bs_reg      <= BRICK_SIZE_RESET;
      level_valid <= 1'b0;
      volume_sum  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        bs_reg <= cfg_data;
      end
      if (cmd.take_item) begin
        if (stat.restart) begin
          level_valid <= 1'b1;
          volume_sum  <= VOL_W'(bar_volume);
        end else begin
          volume_sum <= vol_add[VOL_W] ? {VOL_W{1'b1}} : vol_add[VOL_W-1:0];
        end
      end
      if (cmd.emit && is_last) begin
        volume_sum <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      close_r <= close_in;
      time_r  <= bar_time;
      if (stat.restart) begin
        level <= close_in;
      end
    end
    if (cmd.set_level_div) begin
      level <= (lvl_div == '0) ? close_r : lvl_div;
    end
    if (cmd.div_start && cmd.div_sel == DIV_COUNT) begin
      up_r <= up_move;
    end
    if (cmd.load_count) begin
      n_r   <= n_now;
      cap_r <= cap_now;
    end
    if (cmd.load_share) begin
      share <= div_q;
      cnt   <= '0;
    end
    if (cmd.emit) begin
      brick_time   <= time_r;
      brick_open   <= PRICE_W'(level);
      brick_close  <= PRICE_W'(lvl_step);
      brick_high   <= up_r ? PRICE_W'(lvl_step) : PRICE_W'(level);
      brick_low    <= up_r ? PRICE_W'(level) : PRICE_W'(lvl_step);
      brick_volume <= share;
      brick_up     <= up_r;
      last_brick   <= is_last;
      capped       <= cap_r;
      level        <= lvl_step;
      cnt          <= cnt + NW'(1);
    end
  end

  assign stat.restart  = series_start | ~level_valid;
  assign stat.bs_zero  = (bs == '0);
  assign stat.move     = up_move | dn_move;
  assign stat.div_done = div_done;
  assign stat.out_free = ~out_valid | out_ready;
  assign stat.last     = is_last;

endmodule

@@ hw/rtl/rbg_controller.sv @@
// Controller: sequences item intake, the three divisions and brick emission.
module rbg_controller import rbg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rbg_stat_t stat,
  output rbg_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LEVEL,
    S_CHECK,
    S_DIV_COUNT,
    S_DIV_SHARE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_LEVEL;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (stat.restart && !stat.bs_zero) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_LEVEL;
            state_next    = S_DIV_LEVEL;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_DIV_LEVEL: begin
        if (stat.div_done) begin
          cmd.set_level_div = 1'b1;
          state_next        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bs_zero || !stat.move) begin
          state_next = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_COUNT;
          state_next    = S_DIV_COUNT;
        end
      end
      S_DIV_COUNT: begin
        cmd.div_sel = DIV_SHARE;
        if (stat.div_done) begin
          cmd.load_count = 1'b1;
          cmd.div_start  = 1'b1;
          state_next     = S_DIV_SHARE;
        end
      end
      S_DIV_SHARE: begin
        cmd.div_sel = DIV_SHARE;
        if (stat.div_done) begin
          cmd.load_share = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

@@ hw/rtl/rbg_checker.sv @@
// Port-level checker for the brick generator and its bind to the top level.
module rbg_checker import rbg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PRICE_W-1:0] brick_open,
  input logic [PRICE_W-1:0] brick_close,
  input logic [PRICE_W-1:0] brick_high,
  input logic [PRICE_W-1:0] brick_low,
  input logic [VOL_W-1:0]   brick_volume,
  input logic               brick_up
);

  // a stalled brick transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(brick_close) && $stable(brick_volume))
    else $error("brick changed while stalled");

  // edges follow direction
  a_edges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (brick_up ? (brick_high == brick_close && brick_low == brick_open)
                            : (brick_high == brick_open && brick_low == brick_close)))
    else $error("brick edges do not match direction");

  // every brick moves the level
  a_moves: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> brick_open != brick_close)
    else $error("brick with zero height");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind renko_brick_generator_unit rbg_checker u_rbg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .brick_open   (brick_open),
  .brick_close  (brick_close),
  .brick_high   (brick_high),
  .brick_low    (brick_low),
  .brick_volume (brick_volume),
  .brick_up     (brick_up)
);
